/* hdl/bist_pkg.sv */
`default_nettype none

package bist_pkg;

    // store geometry
    localparam int CAPACITY      = 128;
    localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int VALUE_W       = 32;
    localparam int OP_W          = 2;
    localparam int ENTRY_COUNT_W = 8;

    // operation codes, code 3 acts as a query
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } bist_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_APPEND,
        ST_LAST_RD,
        ST_MOVE,
        ST_FINISH
    } bist_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_step;
        logic append;
        logic read_last;
        logic move;
        logic emit;
    } bist_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic            match;
        logic            exhausted;
        logic            present;
        logic            full;
        logic [OP_W-1:0] op;
        logic            out_free;
    } bist_status_t;

endpackage

`default_nettype wire

/* hdl/bist_ctrl.sv */
`default_nettype none

module bist_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire bist_pkg::bist_status_t status,
    output bist_pkg::bist_cmd_t        cmd
);
    import bist_pkg::*;

    bist_state_t state_reg;
    bist_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.match || status.exhausted) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                priority if (status.op == OP_ADD && !status.present && !status.full) begin
                    state_next = ST_APPEND;
                end else if (status.op == OP_REMOVE && status.present) begin
                    state_next = ST_LAST_RD;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_APPEND:  state_next = ST_FINISH;
            ST_LAST_RD: state_next = ST_MOVE;
            ST_MOVE:    state_next = ST_FINISH;
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SCAN:    cmd.scan_step = 1'b1;
            ST_DECIDE:  cmd           = '0;
            ST_APPEND:  cmd.append    = 1'b1;
            ST_LAST_RD: cmd.read_last = 1'b1;
            ST_MOVE:    cmd.move      = 1'b1;
            ST_FINISH:  cmd.emit      = status.out_free;
            default:    cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/bist_datapath.sv */
`default_nettype none

module bist_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire bist_pkg::bist_cmd_t             cmd,
    output bist_pkg::bist_status_t               status,
    input  wire logic [bist_pkg::OP_W-1:0]       in_op,
    input  wire logic [bist_pkg::VALUE_W-1:0]    in_value,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic                                 out_was_present,
    output logic                                 out_changed,
    output logic [bist_pkg::ENTRY_COUNT_W-1:0]   out_entry_count
);
    import bist_pkg::*;

    logic [VALUE_W-1:0] mem [CAPACITY];

    // control state
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic [CNT_W-1:0]   scan_idx_reg,  scan_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic               m_valid_reg,   m_valid_next;

    // payload
    logic [OP_W-1:0]    op_reg,        op_next;
    logic [VALUE_W-1:0] value_reg,     value_next;
    logic [IDX_W-1:0]   cmp_idx_reg,   cmp_idx_next;
    logic [IDX_W-1:0]   slot_reg,      slot_next;
    logic               present_reg,   present_next;
    logic               changed_reg,   changed_next;
    logic               res_present_reg, res_present_next;
    logic               res_changed_reg, res_changed_next;
    logic [ENTRY_COUNT_W-1:0] res_count_reg, res_count_next;
    logic [VALUE_W-1:0] rd_data_reg;

    logic               scan_issue;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [CNT_W-1:0]   last_pos;
    logic               match;

    assign last_pos   = count_reg - CNT_W'(1);
    assign scan_issue = cmd.scan_step && (scan_idx_reg < count_reg);
    assign match      = cmp_valid_reg && (rd_data_reg == value_reg);

    // one read port, shared by the scan and the last-entry fetch
    assign rd_en   = scan_issue || cmd.read_last;
    assign rd_addr = cmd.read_last ? last_pos[IDX_W-1:0] : scan_idx_reg[IDX_W-1:0];

    // one write port: append at the end or fill the freed slot
    assign wr_en   = cmd.append || cmd.move;
    assign wr_addr = cmd.move ? slot_reg : count_reg[IDX_W-1:0];
    assign wr_data = cmd.move ? rd_data_reg : value_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        count_next       = count_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_valid_next   = 1'b0;
        m_valid_next     = m_valid_reg;
        op_next          = op_reg;
        value_next       = value_reg;
        cmp_idx_next     = cmp_idx_reg;
        slot_next        = slot_reg;
        present_next     = present_reg;
        changed_next     = changed_reg;
        res_present_next = res_present_reg;
        res_changed_next = res_changed_reg;
        res_count_next   = res_count_reg;

        if (cmd.load) begin
            op_next       = in_op;
            value_next    = in_value;
            scan_idx_next = '0;
            present_next  = 1'b0;
            changed_next  = 1'b0;
        end

        if (cmd.scan_step) begin
            if (scan_issue) begin
                cmp_valid_next = 1'b1;
                cmp_idx_next   = scan_idx_reg[IDX_W-1:0];
                scan_idx_next  = scan_idx_reg + CNT_W'(1);
            end
            if (match) begin
                present_next = 1'b1;
                slot_next    = cmp_idx_reg;
            end
        end

        if (cmd.append) begin
            count_next   = count_reg + CNT_W'(1);
            changed_next = 1'b1;
        end

        if (cmd.move) begin
            count_next   = last_pos;
            changed_next = 1'b1;
        end

        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            m_valid_next     = 1'b1;
            res_present_next = present_reg;
            res_changed_next = changed_reg;
            res_count_next   = ENTRY_COUNT_W'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        value_reg       <= value_next;
        cmp_idx_reg     <= cmp_idx_next;
        slot_reg        <= slot_next;
        present_reg     <= present_next;
        changed_reg     <= changed_next;
        res_present_reg <= res_present_next;
        res_changed_reg <= res_changed_next;
        res_count_reg   <= res_count_next;
    end

    always_comb begin
        status.match     = match;
        status.exhausted = !cmp_valid_reg && (scan_idx_reg >= count_reg);
        status.present   = present_reg;
        status.full      = (count_reg == CNT_W'(CAPACITY));
        status.op        = op_reg;
        status.out_free  = !m_valid_reg || m_tready;
    end

    assign m_tvalid        = m_valid_reg;
    assign out_was_present = res_present_reg;
    assign out_changed     = res_changed_reg;
    assign out_entry_count = res_count_reg;

endmodule

`default_nettype wire

/* hdl/bounded_integer_set_table_unit.sv */
// channel | dir | tdata (lsb up)                                | tuser (lsb up)
// --------+-----+-----------------------------------------------+---------------
// s_      | in  | value[31:0]                                   | operation[1:0]
// m_      | out | was_present[0], changed[1], entry_count[9:2]  | -
//
// one item at a time: the next item is accepted only once the result is in the output register
// the scan reads one stored entry per cycle from the entry memory
// remove of a present value adds a read of the last entry and a write-back
// aresetn is synchronous, active low; it empties the set, memory contents are left as they are
// a finished result waits in the output register while the next item is accepted
// a stalled m_ side holds the block only when a second result is ready to go
`default_nettype none

module bounded_integer_set_table_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value[31:0]
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // was_present[0], changed[1], entry_count[9:2], zero[15:10]
);
    import bist_pkg::*;

    bist_cmd_t                cmd;
    bist_status_t             status;
    logic                     res_was_present;
    logic                     res_changed;
    logic [ENTRY_COUNT_W-1:0] res_entry_count;

    // sequencer: accept, scan, decide, update, deliver
    bist_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // entry memory, count, compare and result register
    bist_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .in_op           (s_tuser),
        .in_value        (s_tdata),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .out_was_present (res_was_present),
        .out_changed     (res_changed),
        .out_entry_count (res_entry_count)
    );

    // pack the result, zero fill up to whole bytes
    assign m_tdata = {6'd0, res_entry_count, res_changed, res_was_present};

endmodule

`default_nettype wire

/* hdl/bist_checker.sv */
`default_nettype none

module bist_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);
    import bist_pkg::*;

    // a held result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one item in flight: the input closes right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input open while an item is in flight");

    // a new result only comes out of a busy period
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in flight");

    // count never exceeds the capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[9:2] <= ENTRY_COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a successful add leaves at least one entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] && !m_tdata[0] |-> m_tdata[9:2] != '0)
        else $error("add reported with an empty set");

endmodule

bind bounded_integer_set_table_unit bist_checker u_bist_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
